// ===== src/html_entity_decoder_macros.svh =====
// Assertion macros used by the decoder's RTL
`ifndef HTML_ENTITY_DECODER_MACROS_SVH
`define HTML_ENTITY_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/hed_pkg.sv =====
package hed_pkg;

    localparam int HED_MAX_NAME      = 32;
    localparam int HED_TABLE_ENTRIES = 253;

    localparam logic [20:0] CH_AMP  = 21'h26;
    localparam logic [20:0] CH_SEMI = 21'h3B;
    localparam logic [6:0]  CH_HASH = 7'h23;
    localparam logic [6:0]  CH_X_LO = 7'h78;
    localparam logic [6:0]  CH_X_UP = 7'h58;

    typedef struct packed {
        logic [20:0] ch;
        logic        end_of_text;
    } t_in;

    typedef struct packed {
        logic [31:0] out_char;
        logic        out_last;
    } t_out;

    // Entity name right-justified, zero-padded to eight characters
    typedef struct packed {
        logic [13:0] cp;
        logic [63:0] nm;
    } t_ent;

    function automatic logic is_name_char(input logic [20:0] c);
        return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) ||
               (c >= 21'h30 && c <= 21'h39) || c == 21'h5F || c == 21'h23;
    endfunction

    function automatic t_ent mk(input logic [13:0] cp, input logic [63:0] nm);
        t_ent e;
        e.cp = cp;
        e.nm = nm;
        return e;
    endfunction

    function automatic t_ent hed_entry(input logic [7:0] k);
        t_ent e;
        case (k)
            8'd0: e = mk(14'd198, "AElig");   8'd1: e = mk(14'd193, "Aacute");
            8'd2: e = mk(14'd194, "Acirc");   8'd3: e = mk(14'd192, "Agrave");
            8'd4: e = mk(14'd913, "Alpha");   8'd5: e = mk(14'd197, "Aring");
            8'd6: e = mk(14'd195, "Atilde");  8'd7: e = mk(14'd196, "Auml");
            8'd8: e = mk(14'd914, "Beta");    8'd9: e = mk(14'd199, "Ccedil");
            8'd10: e = mk(14'd935, "Chi");    8'd11: e = mk(14'd8225, "Dagger");
            8'd12: e = mk(14'd916, "Delta");  8'd13: e = mk(14'd208, "ETH");
            8'd14: e = mk(14'd201, "Eacute"); 8'd15: e = mk(14'd202, "Ecirc");
            8'd16: e = mk(14'd200, "Egrave"); 8'd17: e = mk(14'd917, "Epsilon");
            8'd18: e = mk(14'd919, "Eta");    8'd19: e = mk(14'd203, "Euml");
            8'd20: e = mk(14'd915, "Gamma");  8'd21: e = mk(14'd205, "Iacute");
            8'd22: e = mk(14'd206, "Icirc");  8'd23: e = mk(14'd204, "Igrave");
            8'd24: e = mk(14'd921, "Iota");   8'd25: e = mk(14'd207, "Iuml");
            8'd26: e = mk(14'd922, "Kappa");  8'd27: e = mk(14'd923, "Lambda");
            8'd28: e = mk(14'd924, "Mu");     8'd29: e = mk(14'd209, "Ntilde");
            8'd30: e = mk(14'd925, "Nu");     8'd31: e = mk(14'd338, "OElig");
            8'd32: e = mk(14'd211, "Oacute"); 8'd33: e = mk(14'd212, "Ocirc");
            8'd34: e = mk(14'd210, "Ograve"); 8'd35: e = mk(14'd937, "Omega");
            8'd36: e = mk(14'd927, "Omicron"); 8'd37: e = mk(14'd216, "Oslash");
            8'd38: e = mk(14'd213, "Otilde"); 8'd39: e = mk(14'd214, "Ouml");
            8'd40: e = mk(14'd934, "Phi");    8'd41: e = mk(14'd928, "Pi");
            8'd42: e = mk(14'd8243, "Prime"); 8'd43: e = mk(14'd936, "Psi");
            8'd44: e = mk(14'd929, "Rho");    8'd45: e = mk(14'd352, "Scaron");
            8'd46: e = mk(14'd931, "Sigma");  8'd47: e = mk(14'd222, "THORN");
            8'd48: e = mk(14'd932, "Tau");    8'd49: e = mk(14'd920, "Theta");
            8'd50: e = mk(14'd218, "Uacute"); 8'd51: e = mk(14'd219, "Ucirc");
            8'd52: e = mk(14'd217, "Ugrave"); 8'd53: e = mk(14'd933, "Upsilon");
            8'd54: e = mk(14'd220, "Uuml");   8'd55: e = mk(14'd926, "Xi");
            8'd56: e = mk(14'd221, "Yacute"); 8'd57: e = mk(14'd376, "Yuml");
            8'd58: e = mk(14'd918, "Zeta");   8'd59: e = mk(14'd225, "aacute");
            8'd60: e = mk(14'd226, "acirc");  8'd61: e = mk(14'd180, "acute");
            8'd62: e = mk(14'd230, "aelig");  8'd63: e = mk(14'd224, "agrave");
            8'd64: e = mk(14'd8501, "alefsym"); 8'd65: e = mk(14'd945, "alpha");
            8'd66: e = mk(14'd38, "amp");     8'd67: e = mk(14'd8743, "and");
            8'd68: e = mk(14'd8736, "ang");   8'd69: e = mk(14'd39, "apos");
            8'd70: e = mk(14'd229, "aring");  8'd71: e = mk(14'd8776, "asymp");
            8'd72: e = mk(14'd227, "atilde"); 8'd73: e = mk(14'd228, "auml");
            8'd74: e = mk(14'd8222, "bdquo"); 8'd75: e = mk(14'd946, "beta");
            8'd76: e = mk(14'd166, "brvbar"); 8'd77: e = mk(14'd8226, "bull");
            8'd78: e = mk(14'd8745, "cap");   8'd79: e = mk(14'd231, "ccedil");
            8'd80: e = mk(14'd184, "cedil");  8'd81: e = mk(14'd162, "cent");
            8'd82: e = mk(14'd967, "chi");    8'd83: e = mk(14'd710, "circ");
            8'd84: e = mk(14'd9827, "clubs"); 8'd85: e = mk(14'd8773, "cong");
            8'd86: e = mk(14'd169, "copy");   8'd87: e = mk(14'd8629, "crarr");
            8'd88: e = mk(14'd8746, "cup");   8'd89: e = mk(14'd164, "curren");
            8'd90: e = mk(14'd8659, "dArr");  8'd91: e = mk(14'd8224, "dagger");
            8'd92: e = mk(14'd8595, "darr");  8'd93: e = mk(14'd176, "deg");
            8'd94: e = mk(14'd948, "delta");  8'd95: e = mk(14'd9830, "diams");
            8'd96: e = mk(14'd247, "divide"); 8'd97: e = mk(14'd233, "eacute");
            8'd98: e = mk(14'd234, "ecirc");  8'd99: e = mk(14'd232, "egrave");
            8'd100: e = mk(14'd8709, "empty"); 8'd101: e = mk(14'd8195, "emsp");
            8'd102: e = mk(14'd8194, "ensp"); 8'd103: e = mk(14'd949, "epsilon");
            8'd104: e = mk(14'd8801, "equiv"); 8'd105: e = mk(14'd951, "eta");
            8'd106: e = mk(14'd240, "eth");   8'd107: e = mk(14'd235, "euml");
            8'd108: e = mk(14'd8364, "euro"); 8'd109: e = mk(14'd8707, "exist");
            8'd110: e = mk(14'd402, "fnof");  8'd111: e = mk(14'd8704, "forall");
            8'd112: e = mk(14'd189, "frac12"); 8'd113: e = mk(14'd188, "frac14");
            8'd114: e = mk(14'd190, "frac34"); 8'd115: e = mk(14'd8260, "frasl");
            8'd116: e = mk(14'd947, "gamma"); 8'd117: e = mk(14'd8805, "ge");
            8'd118: e = mk(14'd62, "gt");     8'd119: e = mk(14'd8660, "hArr");
            8'd120: e = mk(14'd8596, "harr"); 8'd121: e = mk(14'd9829, "hearts");
            8'd122: e = mk(14'd8230, "hellip"); 8'd123: e = mk(14'd237, "iacute");
            8'd124: e = mk(14'd238, "icirc"); 8'd125: e = mk(14'd161, "iexcl");
            8'd126: e = mk(14'd236, "igrave"); 8'd127: e = mk(14'd8465, "image");
            8'd128: e = mk(14'd8734, "infin"); 8'd129: e = mk(14'd8747, "int");
            8'd130: e = mk(14'd953, "iota");  8'd131: e = mk(14'd191, "iquest");
            8'd132: e = mk(14'd8712, "isin"); 8'd133: e = mk(14'd239, "iuml");
            8'd134: e = mk(14'd954, "kappa"); 8'd135: e = mk(14'd8656, "lArr");
            8'd136: e = mk(14'd955, "lambda"); 8'd137: e = mk(14'd9001, "lang");
            8'd138: e = mk(14'd171, "laquo"); 8'd139: e = mk(14'd8592, "larr");
            8'd140: e = mk(14'd8968, "lceil"); 8'd141: e = mk(14'd8220, "ldquo");
            8'd142: e = mk(14'd8804, "le");   8'd143: e = mk(14'd8970, "lfloor");
            8'd144: e = mk(14'd8727, "lowast"); 8'd145: e = mk(14'd9674, "loz");
            8'd146: e = mk(14'd8206, "lrm");  8'd147: e = mk(14'd8249, "lsaquo");
            8'd148: e = mk(14'd8216, "lsquo"); 8'd149: e = mk(14'd60, "lt");
            8'd150: e = mk(14'd175, "macr");  8'd151: e = mk(14'd8212, "mdash");
            8'd152: e = mk(14'd181, "micro"); 8'd153: e = mk(14'd183, "middot");
            8'd154: e = mk(14'd8722, "minus"); 8'd155: e = mk(14'd956, "mu");
            8'd156: e = mk(14'd8711, "nabla"); 8'd157: e = mk(14'd160, "nbsp");
            8'd158: e = mk(14'd8211, "ndash"); 8'd159: e = mk(14'd8800, "ne");
            8'd160: e = mk(14'd8715, "ni");   8'd161: e = mk(14'd172, "not");
            8'd162: e = mk(14'd8713, "notin"); 8'd163: e = mk(14'd8836, "nsub");
            8'd164: e = mk(14'd241, "ntilde"); 8'd165: e = mk(14'd957, "nu");
            8'd166: e = mk(14'd243, "oacute"); 8'd167: e = mk(14'd244, "ocirc");
            8'd168: e = mk(14'd339, "oelig"); 8'd169: e = mk(14'd242, "ograve");
            8'd170: e = mk(14'd8254, "oline"); 8'd171: e = mk(14'd969, "omega");
            8'd172: e = mk(14'd959, "omicron"); 8'd173: e = mk(14'd8853, "oplus");
            8'd174: e = mk(14'd8744, "or");   8'd175: e = mk(14'd170, "ordf");
            8'd176: e = mk(14'd186, "ordm");  8'd177: e = mk(14'd248, "oslash");
            8'd178: e = mk(14'd245, "otilde"); 8'd179: e = mk(14'd8855, "otimes");
            8'd180: e = mk(14'd246, "ouml");  8'd181: e = mk(14'd182, "para");
            8'd182: e = mk(14'd8706, "part"); 8'd183: e = mk(14'd8240, "permil");
            8'd184: e = mk(14'd8869, "perp"); 8'd185: e = mk(14'd966, "phi");
            8'd186: e = mk(14'd960, "pi");    8'd187: e = mk(14'd982, "piv");
            8'd188: e = mk(14'd177, "plusmn"); 8'd189: e = mk(14'd163, "pound");
            8'd190: e = mk(14'd8242, "prime"); 8'd191: e = mk(14'd8719, "prod");
            8'd192: e = mk(14'd8733, "prop"); 8'd193: e = mk(14'd968, "psi");
            8'd194: e = mk(14'd34, "quot");   8'd195: e = mk(14'd8658, "rArr");
            8'd196: e = mk(14'd8730, "radic"); 8'd197: e = mk(14'd9002, "rang");
            8'd198: e = mk(14'd187, "raquo"); 8'd199: e = mk(14'd8594, "rarr");
            8'd200: e = mk(14'd8969, "rceil"); 8'd201: e = mk(14'd8221, "rdquo");
            8'd202: e = mk(14'd8476, "real"); 8'd203: e = mk(14'd174, "reg");
            8'd204: e = mk(14'd8971, "rfloor"); 8'd205: e = mk(14'd961, "rho");
            8'd206: e = mk(14'd8207, "rlm");  8'd207: e = mk(14'd8250, "rsaquo");
            8'd208: e = mk(14'd8217, "rsquo"); 8'd209: e = mk(14'd8218, "sbquo");
            8'd210: e = mk(14'd353, "scaron"); 8'd211: e = mk(14'd8901, "sdot");
            8'd212: e = mk(14'd167, "sect");  8'd213: e = mk(14'd173, "shy");
            8'd214: e = mk(14'd963, "sigma"); 8'd215: e = mk(14'd962, "sigmaf");
            8'd216: e = mk(14'd8764, "sim");  8'd217: e = mk(14'd9824, "spades");
            8'd218: e = mk(14'd8834, "sub");  8'd219: e = mk(14'd8838, "sube");
            8'd220: e = mk(14'd8721, "sum");  8'd221: e = mk(14'd8835, "sup");
            8'd222: e = mk(14'd185, "sup1");  8'd223: e = mk(14'd178, "sup2");
            8'd224: e = mk(14'd179, "sup3");  8'd225: e = mk(14'd8839, "supe");
            8'd226: e = mk(14'd223, "szlig"); 8'd227: e = mk(14'd964, "tau");
            8'd228: e = mk(14'd8756, "there4"); 8'd229: e = mk(14'd952, "theta");
            8'd230: e = mk(14'd977, "thetasym"); 8'd231: e = mk(14'd8201, "thinsp");
            8'd232: e = mk(14'd254, "thorn"); 8'd233: e = mk(14'd732, "tilde");
            8'd234: e = mk(14'd215, "times"); 8'd235: e = mk(14'd8482, "trade");
            8'd236: e = mk(14'd8657, "uArr"); 8'd237: e = mk(14'd250, "uacute");
            8'd238: e = mk(14'd8593, "uarr"); 8'd239: e = mk(14'd251, "ucirc");
            8'd240: e = mk(14'd249, "ugrave"); 8'd241: e = mk(14'd168, "uml");
            8'd242: e = mk(14'd978, "upsih"); 8'd243: e = mk(14'd965, "upsilon");
            8'd244: e = mk(14'd252, "uuml");  8'd245: e = mk(14'd8472, "weierp");
            8'd246: e = mk(14'd958, "xi");    8'd247: e = mk(14'd253, "yacute");
            8'd248: e = mk(14'd165, "yen");   8'd249: e = mk(14'd255, "yuml");
            8'd250: e = mk(14'd950, "zeta");  8'd251: e = mk(14'd8205, "zwj");
            8'd252: e = mk(14'd8204, "zwnj");
            default: e = mk(14'd0, 64'd0);
        endcase
        return e;
    endfunction

endpackage

// ===== src/hed_ram.sv =====
module hed_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/html_entity_decoder.sv =====
// HTML character entity decoder. One character is taken per item and copied through;
// '&' opens an entity whose name is held in a small RAM and resolved when the entity
// closes, as a decimal or hex number or by searching the 253-entry name table. A plain
// character is accepted and then emitted; a name character is only stored. Closing an
// entity reads its name back from the RAM, then searches up to 253 table entries, one per
// cycle, through a single 64-bit name comparator, then emits the decoded character, or the
// '&' and the raw name characters; the name RAM's registered read port sets the pace of
// the read-back and of the raw name output. Output stalls hold the sequencer. The block
// takes no item while it works.
`include "html_entity_decoder_macros.svh"
module html_entity_decoder #(
    parameter int MAX_NAME      = hed_pkg::HED_MAX_NAME,
    parameter int TABLE_ENTRIES = hed_pkg::HED_TABLE_ENTRIES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  hed_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output hed_pkg::t_out o_data,
    input  logic          i_stall
);
    import hed_pkg::*;

    localparam int LW = $clog2(MAX_NAME + 1);
    localparam int AW = $clog2(MAX_NAME);
    localparam int KW = $clog2(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_KEYRD, S_SEARCH, S_CODE, S_RAWAMP, S_RAWNAME, S_SEMI, S_TAIL, S_FRESH
    } t_state;

    t_state      r_state;
    logic        r_inent;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_idx;
    logic        r_ph;
    logic [20:0] r_c;
    logic        r_eot;
    logic        r_semi;
    logic        r_fresh;
    logic        r_tail;
    logic [63:0] r_key;
    logic        r_num;
    logic        r_hex;
    logic        r_stop;
    logic [31:0] r_val;
    logic [KW-1:0] r_k;
    logic        r_ovalid;
    t_out        r_odata;

    logic        can_ld;
    logic        ld_out;
    logic        namec;
    logic        ram_we;
    logic [6:0]  rd;
    logic [4:0]  dig;
    logic        dig_ok;
    logic [35:0] n_wide;
    logic [31:0] n_val;
    t_ent        ent;
    t_state      n_after;
    logic        last_char;

    hed_ram #(.WIDTH(7), .DEPTH(MAX_NAME)) u_name (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_data.ch[6:0]),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign can_ld  = !r_ovalid || !i_stall;
    assign namec   = is_name_char(i_data.ch);
    assign ram_we  = (r_state == S_IDLE) && i_valid && r_inent && namec &&
                     (r_len != LW'(MAX_NAME));

    // load the output register this cycle
    always_comb begin
        case (r_state)
            S_CODE, S_RAWAMP, S_SEMI, S_TAIL: ld_out = can_ld;
            S_RAWNAME: ld_out = r_ph && can_ld;
            S_FRESH: ld_out = can_ld && !(r_c == CH_AMP && !r_eot);
            default: ld_out = 1'b0;
        endcase
    end

    // digit value, bit 4 flags a non-digit
    always_comb begin
        if (rd >= 7'h30 && rd <= 7'h39) begin
            dig = {1'b0, 4'(rd - 7'h30)};
        end else if (rd >= 7'h61 && rd <= 7'h66) begin
            dig = {1'b0, 4'(rd - 7'h57)};
        end else if (rd >= 7'h41 && rd <= 7'h46) begin
            dig = {1'b0, 4'(rd - 7'h37)};
        end else begin
            dig = 5'h10;
        end
        dig_ok = !dig[4] && (r_hex || dig[3:0] <= 4'd9);
        if (r_hex) begin
            n_wide = {r_val, 4'b0} + {32'b0, dig[3:0]};
        end else begin
            n_wide = {1'b0, r_val, 3'b0} + {3'b0, r_val, 1'b0} + {32'b0, dig[3:0]};
        end
        n_val = (n_wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : n_wide[31:0];
    end

    assign ent       = hed_entry(8'(r_k));
    assign last_char = (r_idx == r_len - LW'(1));
    assign n_after   = r_semi ? S_SEMI : r_tail ? S_TAIL : r_fresh ? S_FRESH : S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inent  <= 1'b0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_c     <= i_data.ch;
                        r_eot   <= i_data.end_of_text;
                        r_semi  <= 1'b0;
                        r_fresh <= 1'b0;
                        r_tail  <= 1'b0;
                        r_idx   <= '0;
                        r_ph    <= 1'b0;
                        r_num   <= 1'b0;
                        r_hex   <= 1'b0;
                        r_stop  <= 1'b0;
                        r_val   <= '0;
                        r_key   <= '0;
                        r_k     <= '0;
                        if (!r_inent) begin
                            r_state <= S_FRESH;
                        end else if (namec) begin
                            if (r_len != LW'(MAX_NAME)) begin
                                r_len <= r_len + LW'(1);
                                if (i_data.end_of_text) begin
                                    r_state <= S_KEYRD;
                                end
                            end else begin
                                // name overflow: flush raw
                                r_tail  <= 1'b1;
                                r_state <= S_RAWAMP;
                            end
                        end else begin
                            r_semi  <= (i_data.ch == CH_SEMI);
                            r_fresh <= (i_data.ch != CH_SEMI);
                            r_state <= S_KEYRD;
                        end
                    end
                end
                S_KEYRD: begin
                    if (!r_ph) begin
                        if (r_idx == r_len) begin
                            r_idx <= '0;
                            if (r_len == '0) begin
                                r_state <= S_RAWAMP;
                            end else if (r_num) begin
                                r_state <= (r_val != '0) ? S_CODE : S_RAWAMP;
                            end else if (r_len <= LW'(8)) begin
                                r_state <= S_SEARCH;
                            end else begin
                                r_state <= S_RAWAMP;
                            end
                        end else begin
                            r_ph <= 1'b1;
                        end
                    end else begin
                        r_ph  <= 1'b0;
                        r_idx <= r_idx + LW'(1);
                        r_key <= {r_key[55:0], 1'b0, rd};
                        if (r_idx == '0) begin
                            r_num <= (rd == CH_HASH);
                        end else if (r_idx == LW'(1) && (rd == CH_X_LO || rd == CH_X_UP)) begin
                            r_hex <= 1'b1;
                        end else if (!r_stop) begin
                            if (!dig_ok) begin
                                r_stop <= 1'b1;
                            end else begin
                                r_val <= n_val;
                            end
                        end
                    end
                end
                S_SEARCH: begin
                    if (ent.nm == r_key) begin
                        r_val   <= {18'b0, ent.cp};
                        r_state <= S_CODE;
                    end else if (r_k == KW'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_RAWAMP;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_CODE: begin
                    if (can_ld) begin
                        r_odata  <= '{out_char: r_val, out_last: r_eot && !r_fresh};
                        r_inent  <= 1'b0;
                        r_len    <= '0;
                        r_state  <= r_fresh ? S_FRESH : S_IDLE;
                    end
                end
                S_RAWAMP: begin
                    if (can_ld) begin
                        r_odata  <= '{out_char: {11'b0, CH_AMP},
                                      out_last: r_eot && !r_fresh && !r_semi && !r_tail &&
                                                (r_len == '0)};
                        r_idx    <= '0;
                        r_ph     <= 1'b0;
                        if (r_len != '0) begin
                            r_state <= S_RAWNAME;
                        end else begin
                            r_inent <= 1'b0;
                            r_state <= n_after;
                        end
                    end
                end
                S_RAWNAME: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (can_ld) begin
                        r_odata  <= '{out_char: {25'b0, rd},
                                      out_last: r_eot && !r_fresh && !r_semi && !r_tail &&
                                                last_char};
                        r_ph     <= 1'b0;
                        r_idx    <= r_idx + LW'(1);
                        if (last_char) begin
                            r_inent <= 1'b0;
                            r_len   <= '0;
                            r_state <= n_after;
                        end
                    end
                end
                S_SEMI: begin
                    if (can_ld) begin
                        r_odata  <= '{out_char: {11'b0, CH_SEMI}, out_last: r_eot};
                        r_state  <= S_IDLE;
                    end
                end
                S_TAIL: begin
                    if (can_ld) begin
                        r_odata  <= '{out_char: {11'b0, r_c}, out_last: r_eot};
                        r_state  <= S_IDLE;
                    end
                end
                S_FRESH: begin
                    if (r_c == CH_AMP && !r_eot) begin
                        r_inent <= 1'b1;
                        r_len   <= '0;
                        r_state <= S_IDLE;
                    end else if (can_ld) begin
                        r_odata  <= '{out_char: {11'b0, r_c}, out_last: r_eot};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLY(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LW'(MAX_NAME))
    `ASSERT_IMPLY(a_search_key, i_clk, i_rst_n, r_state == S_SEARCH, !r_num && r_len <= LW'(8))
    `ASSERT_NEXT(a_eot_closes, i_clk, i_rst_n, (r_state == S_FRESH) && r_eot, !r_inent)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hed_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int HOLD_CYCLES    = 300;

    // name=code pairs of the entity name lookup
    localparam string ENTITY_LIST = {
        "AElig=198 Aacute=193 Acirc=194 Agrave=192 Alpha=913 Aring=197 Atilde=195 ",
        "Auml=196 Beta=914 Ccedil=199 Chi=935 Dagger=8225 Delta=916 ETH=208 ",
        "Eacute=201 Ecirc=202 Egrave=200 Epsilon=917 Eta=919 Euml=203 Gamma=915 ",
        "Iacute=205 Icirc=206 Igrave=204 Iota=921 Iuml=207 Kappa=922 Lambda=923 ",
        "Mu=924 Ntilde=209 Nu=925 OElig=338 Oacute=211 Ocirc=212 Ograve=210 ",
        "Omega=937 Omicron=927 Oslash=216 Otilde=213 Ouml=214 Phi=934 Pi=928 ",
        "Prime=8243 Psi=936 Rho=929 Scaron=352 Sigma=931 THORN=222 Tau=932 ",
        "Theta=920 Uacute=218 Ucirc=219 Ugrave=217 Upsilon=933 Uuml=220 Xi=926 ",
        "Yacute=221 Yuml=376 Zeta=918 aacute=225 acirc=226 acute=180 aelig=230 ",
        "agrave=224 alefsym=8501 alpha=945 amp=38 and=8743 ang=8736 apos=39 ",
        "aring=229 asymp=8776 atilde=227 auml=228 bdquo=8222 beta=946 brvbar=166 ",
        "bull=8226 cap=8745 ccedil=231 cedil=184 cent=162 chi=967 circ=710 ",
        "clubs=9827 cong=8773 copy=169 crarr=8629 cup=8746 curren=164 dArr=8659 ",
        "dagger=8224 darr=8595 deg=176 delta=948 diams=9830 divide=247 eacute=233 ",
        "ecirc=234 egrave=232 empty=8709 emsp=8195 ensp=8194 epsilon=949 ",
        "equiv=8801 eta=951 eth=240 euml=235 euro=8364 exist=8707 fnof=402 ",
        "forall=8704 frac12=189 frac14=188 frac34=190 frasl=8260 gamma=947 ",
        "ge=8805 gt=62 hArr=8660 harr=8596 hearts=9829 hellip=8230 iacute=237 ",
        "icirc=238 iexcl=161 igrave=236 image=8465 infin=8734 int=8747 iota=953 ",
        "iquest=191 isin=8712 iuml=239 kappa=954 lArr=8656 lambda=955 lang=9001 ",
        "laquo=171 larr=8592 lceil=8968 ldquo=8220 le=8804 lfloor=8970 ",
        "lowast=8727 loz=9674 lrm=8206 lsaquo=8249 lsquo=8216 lt=60 macr=175 ",
        "mdash=8212 micro=181 middot=183 minus=8722 mu=956 nabla=8711 nbsp=160 ",
        "ndash=8211 ne=8800 ni=8715 not=172 notin=8713 nsub=8836 ntilde=241 ",
        "nu=957 oacute=243 ocirc=244 oelig=339 ograve=242 oline=8254 omega=969 ",
        "omicron=959 oplus=8853 or=8744 ordf=170 ordm=186 oslash=248 otilde=245 ",
        "otimes=8855 ouml=246 para=182 part=8706 permil=8240 perp=8869 phi=966 ",
        "pi=960 piv=982 plusmn=177 pound=163 prime=8242 prod=8719 prop=8733 ",
        "psi=968 quot=34 rArr=8658 radic=8730 rang=9002 raquo=187 rarr=8594 ",
        "rceil=8969 rdquo=8221 real=8476 reg=174 rfloor=8971 rho=961 rlm=8207 ",
        "rsaquo=8250 rsquo=8217 sbquo=8218 scaron=353 sdot=8901 sect=167 shy=173 ",
        "sigma=963 sigmaf=962 sim=8764 spades=9824 sub=8834 sube=8838 sum=8721 ",
        "sup=8835 sup1=185 sup2=178 sup3=179 supe=8839 szlig=223 tau=964 ",
        "there4=8756 theta=952 thetasym=977 thinsp=8201 thorn=254 tilde=732 ",
        "times=215 trade=8482 uArr=8657 uacute=250 uarr=8593 ucirc=251 ",
        "ugrave=249 uml=168 upsih=978 upsilon=965 uuml=252 weierp=8472 xi=958 ",
        "yacute=253 yen=165 yuml=255 zeta=950 zwj=8205 zwnj=8204 "
    };

    class decoded_text_board;
        int unsigned  entity_code[string];
        string        entity_names[$];
        t_out         pending_chars[$];
        int           errors;
        bit           in_name;
        logic [6:0]   name_chars[HED_MAX_NAME];
        int           name_len;
        logic [31:0]  produced[$];

        function new();
            int st;
            int eq;
            st = 0;
            eq = 0;
            errors = 0;
            in_name = 0;
            name_len = 0;
            for (int i = 0; i < ENTITY_LIST.len(); i++) begin
                if (ENTITY_LIST[i] == "=") begin
                    eq = i;
                end else if (ENTITY_LIST[i] == " ") begin
                    entity_names = {entity_names, ENTITY_LIST.substr(st, eq - 1)};
                    entity_code[ENTITY_LIST.substr(st, eq - 1)] =
                        ENTITY_LIST.substr(eq + 1, i - 1).atoi();
                    st = i + 1;
                end
            end
        endfunction

        function automatic bit name_char(logic [20:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   (c >= "0" && c <= "9") || c == "_" || c == CH_HASH;
        endfunction

        function automatic int digit_of(logic [6:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        function automatic logic [31:0] resolve_name();
            int base;
            int k;
            int d;
            logic [63:0] v;
            string key;
            if (name_len == 0) return 0;
            if (name_chars[0] == CH_HASH) begin
                base = 10;
                k = 1;
                v = 0;
                if (name_len > 1 && (name_chars[1] == CH_X_LO || name_chars[1] == CH_X_UP)) begin
                    base = 16;
                    k = 2;
                end
                for (; k < name_len; k++) begin
                    d = digit_of(name_chars[k]);
                    if (d < 0 || d >= base) break;
                    v = v * base + d;
                    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
                end
                return v[31:0];
            end
            key = "";
            for (k = 0; k < name_len; k++) key = $sformatf("%s%c", key, name_chars[k]);
            if (entity_code.exists(key)) return entity_code[key];
            return 0;
        endfunction

        function automatic void emit_raw();
            produced = {produced, 32'(CH_AMP)};
            for (int k = 0; k < name_len; k++) produced = {produced, 32'(name_chars[k])};
        endfunction

        function automatic void close_name(bit semi);
            logic [31:0] code;
            code = resolve_name();
            if (code != 0) begin
                produced = {produced, code};
            end else begin
                emit_raw();
                if (semi) produced = {produced, 32'(CH_SEMI)};
            end
            in_name = 0;
            name_len = 0;
        endfunction

        function automatic void note_input(t_in it);
            bit fresh;
            t_out r;
            fresh = 1;
            produced.delete();
            if (in_name) begin
                if (name_char(it.ch)) begin
                    fresh = 0;
                    if (name_len < HED_MAX_NAME) begin
                        name_chars[name_len] = it.ch[6:0];
                        name_len++;
                        if (it.end_of_text) close_name(0);
                    end else begin
                        // flush an overlong name raw
                        emit_raw();
                        produced = {produced, 32'(it.ch)};
                        in_name = 0;
                        name_len = 0;
                    end
                end else begin
                    fresh = (it.ch != CH_SEMI);
                    close_name(!fresh);
                end
            end
            if (fresh) begin
                if (it.ch == CH_AMP && !it.end_of_text) begin
                    in_name = 1;
                    name_len = 0;
                end else begin
                    produced = {produced, 32'(it.ch)};
                end
            end
            if (it.end_of_text) begin
                in_name = 0;
                name_len = 0;
            end
            foreach (produced[k]) begin
                r.out_char = produced[k];
                r.out_last = it.end_of_text && (k == produced.size() - 1);
                pending_chars = {pending_chars, r};
            end
        endfunction

        function automatic void check_result(t_out got);
            t_out want;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected item char=%0d last=%0d", $time,
                         got.out_char, got.out_last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                $display("%0t: out_char expected %0d actual %0d", $time,
                         want.out_char, got.out_char);
                errors++;
            end
            if (got.out_last !== want.out_last) begin
                $display("%0t: out_last expected %0d actual %0d", $time,
                         want.out_last, got.out_last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    t_in  i_data;
    logic o_stall;
    logic o_valid;
    t_out o_data;
    logic i_stall;

    decoded_text_board board;
    t_in  text_items[$];
    int   snd_pct;
    int   rcv_pct;
    int   hold_left;
    bit   hold_req;
    int   quiet_cycles;
    localparam string NAME_SET =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_#";
    localparam string HEX_SET = "0123456789abcdefABCDEFgx";

    html_entity_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) board.note_input(i_data);
            if (o_valid && !i_stall) board.check_result(o_data);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAIL html_entity_decoder");
                    $finish;
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rcv_pct);
            end
        end
    end

    task automatic add_char(logic [20:0] c, bit eot);
        t_in it;
        it.ch = c;
        it.end_of_text = eot;
        text_items = {text_items, it};
    endtask

    task automatic add_text(string s, bit eot_end);
        for (int k = 0; k < s.len(); k++) add_char(21'(s[k]), eot_end && k == s.len() - 1);
    endtask

    task automatic add_random_piece();
        int kind;
        int n;
        string nm;
        repeat ($urandom_range(3)) begin
            if ($urandom_range(3) == 0) begin
                add_char(21'($urandom_range(1114111)), $urandom_range(19) == 0);
            end else begin
                add_char(21'($urandom_range(32, 126)), $urandom_range(19) == 0);
            end
        end
        add_char(CH_AMP, $urandom_range(24) == 0);
        kind = $urandom_range(6);
        nm = "";
        case (kind)
            0, 1: nm = board.entity_names[$urandom_range(board.entity_names.size() - 1)];
            2: begin
                nm = "#";
                repeat ($urandom_range(1, 12)) nm = {nm, $sformatf("%0d", $urandom_range(9))};
            end
            3: begin
                nm = ($urandom_range(1)) ? "#x" : "#X";
                n = $urandom_range(1, 10);
                repeat (n) nm = $sformatf("%s%c", nm, HEX_SET[$urandom_range(23)]);
            end
            4: repeat ($urandom_range(1, 6))
                   nm = $sformatf("%s%c", nm, NAME_SET[$urandom_range(NAME_SET.len() - 1)]);
            5: repeat ($urandom_range(HED_MAX_NAME + 1, HED_MAX_NAME + 4))
                   nm = $sformatf("%s%c", nm, NAME_SET[$urandom_range(51)]);
            default: nm = "";
        endcase
        for (int k = 0; k < nm.len(); k++) add_char(21'(nm[k]), $urandom_range(39) == 0);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: add_char(CH_SEMI, $urandom_range(9) == 0);
            6: add_char(CH_AMP, 1'b0);
            7: add_char(21'($urandom_range(32, 47)), $urandom_range(3) == 0);
            default: add_char(21'($urandom_range(1114111)), 1'b1);
        endcase
    endtask

    task automatic send_item(t_in d);
        while ($urandom_range(99) < snd_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic run_phase(int count, int s_pct, int r_pct);
        snd_pct = s_pct;
        rcv_pct = r_pct;
        text_items.delete();
        while (text_items.size() < count) add_random_piece();
        foreach (text_items[k]) send_item(text_items[k]);
    endtask

    initial begin
        board = new();
        i_clk = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        i_stall = 0;
        hold_left = 0;
        hold_req = 0;
        quiet_cycles = 0;
        snd_pct = 17;
        rcv_pct = 70;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_text("&amp;&#65 &;&#x0x1F;&#0;&#X4a&thetasym", 1'b0);
        add_char(21'd0, 1'b0);
        add_char(21'd1114111, 1'b1);
        add_text("&nbsp&", 1'b1);
        foreach (text_items[k]) send_item(text_items[k]);

        hold_req = 1;
        run_phase(85, 17, 70);
        run_phase(85, 70, 17);
        run_phase(85, 0, 0);
        i_valid <= 1'b0;

        while (board.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending_chars.size() == 0) begin
            $display("PASS html_entity_decoder");
        end else begin
            $display("FAIL html_entity_decoder");
        end
        $finish;
    end
endmodule
